// ===== hw/rtl/cie76_pkg.sv =====
package cie76_pkg;

   // channel code width
   localparam int CHANNEL_BITS = 8;
   localparam int LIN_ENTRIES  = 1 << CHANNEL_BITS;
   localparam int LIN_BITS     = 17;
   localparam int DIST_BITS    = 13;
   localparam int F_BITS       = 21;
   localparam int LAB_BITS     = 16;

   localparam logic [DIST_BITS-1:0] THRESH_RESET = DIST_BITS'(80);
   localparam logic [DIST_BITS-1:0] DIST_MAX     = '1;

   typedef logic [CHANNEL_BITS-1:0] code_type;

   typedef struct packed {
      code_type first_red;
      code_type first_green;
      code_type first_blue;
      code_type second_red;
      code_type second_green;
      code_type second_blue;
   } req_payload_type;

   typedef struct packed {
      logic [DIST_BITS-1:0] distance;
      logic                 is_close;
   } rsp_payload_type;

   typedef struct packed {
      logic signed [LAB_BITS-1:0] l;
      logic signed [LAB_BITS-1:0] a;
      logic signed [LAB_BITS-1:0] b;
   } lab_type;

   // pipeline depths
   localparam int CBRT_STAGES = 21;
   localparam int LAB_DEPTH   = 8 + CBRT_STAGES + 1;
   localparam int SQRT_STAGES = 16;
   localparam int PIPE_DEPTH  = LAB_DEPTH + 3 + SQRT_STAGES;

   // sRGB linearization table, Q1.16, built at elaboration
   typedef logic [LIN_ENTRIES-1:0][LIN_BITS-1:0] lin_rom_type;
   localparam int WIDE_BITS = 384;

   function automatic lin_rom_type lin_rom_build();
      lin_rom_type rom;
      logic [WIDE_BITS-1:0] dd;
      logic [WIDE_BITS-1:0] nn;
      logic [WIDE_BITS-1:0] pw;
      longint unsigned m;
      longint unsigned cv;
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned mid;
      rom = '0;
      m   = (longint'(1) << CHANNEL_BITS) - 1;
      dd  = WIDE_BITS'(1);
      for (int k = 0; k < 12; k++) begin
         dd = dd * WIDE_BITS'(1055 * m);
      end
      for (int c = 0; c < LIN_ENTRIES; c++) begin
         cv = longint'(c);
         if (100000 * cv <= 4045 * m) begin
            // round half up of c/(12.92m): largest r with r*2584m <= 13107200c + 1292m
            lo = 0;
            hi = 65536;
            while (lo < hi) begin
               mid = (lo + hi + 1) >> 1;
               if (mid * (2 * 1292 * m) <= 2 * 6553600 * cv + 1292 * m) begin
                  lo = mid;
               end else begin
                  hi = mid - 1;
               end
            end
            rom[c] = LIN_BITS'(lo);
         end else begin
            nn = WIDE_BITS'(1);
            for (int k = 0; k < 12; k++) begin
               nn = nn * WIDE_BITS'(1000 * cv + 55 * m);
            end
            nn = nn << 85;
            lo = 0;
            hi = 65536;
            while (lo < hi) begin
               mid = (lo + hi + 1) >> 1;
               pw  = dd;
               for (int k = 0; k < 5; k++) begin
                  pw = pw * WIDE_BITS'(2 * mid - 1);
               end
               if (pw <= nn) begin
                  lo = mid;
               end else begin
                  hi = mid - 1;
               end
            end
            rom[c] = LIN_BITS'(lo);
         end
      end
      return rom;
   endfunction

   localparam lin_rom_type LIN_ROM = lin_rom_build();

   // RGB -> XYZ matrix, scaled by 1e4
   localparam logic [13:0] XYZ_COEF [3][3] = '{
      '{14'd4124, 14'd3576, 14'd1805},
      '{14'd2126, 14'd7152, 14'd722},
      '{14'd193,  14'd1192, 14'd9505}
   };

   // t = floor((MUL*s + ADD) / DEN), estimated by reciprocal, fixed by one step
   localparam int DIV_SHIFT = 34;
   localparam longint unsigned DIV_MUL [3] = '{64'd2560, 64'd256, 64'd2560};
   localparam longint unsigned DIV_ADD [3] = '{64'd47523, 64'd5000, 64'd54441};
   localparam longint unsigned DIV_DEN [3] = '{64'd95047, 64'd10000, 64'd108883};
   localparam longint unsigned DIV_RECIP [3] = '{
      (64'd1 << DIV_SHIFT) * 64'd2560 / 64'd95047,
      (64'd1 << DIV_SHIFT) * 64'd256 / 64'd10000,
      (64'd1 << DIV_SHIFT) * 64'd2560 / 64'd108883
   };
   localparam longint unsigned DIV_BIAS [3] = '{
      (64'd1 << DIV_SHIFT) * 64'd47523 / 64'd95047,
      (64'd1 << DIV_SHIFT) * 64'd5000 / 64'd10000,
      (64'd1 << DIV_SHIFT) * 64'd54441 / 64'd108883
   };

   // linear segment of f(t): (7.787t + 16/116) in Q0.20
   localparam longint unsigned LIN_MUL   = 64'd7787 * 64'd116;
   localparam longint unsigned LIN_ADD   = (64'd16 << 20) * 64'd16000 + 64'd928000;
   localparam longint unsigned LIN_DEN   = 64'd1856000;
   localparam longint unsigned LIN_RECIP = (64'd1 << DIV_SHIFT) * LIN_MUL / LIN_DEN;
   localparam longint unsigned LIN_BIAS  = ((LIN_ADD / LIN_DEN) << DIV_SHIFT) +
                                           (((LIN_ADD % LIN_DEN) << DIV_SHIFT) / LIN_DEN);
   localparam longint unsigned LAB_KNEE  = (64'd8856 << 24) / 64'd1000000;
   localparam int LAB_L_OFFSET = 16 << 20;

endpackage

// ===== hw/rtl/cie76_color_difference_unit.sv =====
// Channel   Ports                               Moves
// --------  ----------------------------------  ---------------------------------
// request   req_valid, req_ready, req_payload   two sRGB colors, six channel codes
// response  rsp_valid, rsp_ready, rsp_payload   delta E (Q9.4) and is_close flag
// csr       csr_valid, csr_ready, csr_data      close_threshold (Q9.4)
//
// Fully pipelined: one transaction per cycle while the response side does not stall.
// Depth is set by the cube root (21 stages, one bit each) and the square root
// (16 stages, one bit each), plus ROM, matrix, divider and Lab stages.
// Synchronous reset clears the valid bits and sets close_threshold to 5.0.
// A stalled response freezes the whole pipe; req_ready is low exactly while a
// finished result waits and rsp_ready is low.
module cie76_color_difference_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  cie76_pkg::req_payload_type     req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output cie76_pkg::rsp_payload_type     rsp_payload,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [cie76_pkg::DIST_BITS-1:0] csr_data
);

   localparam int DEPTH = cie76_pkg::PIPE_DEPTH;
   localparam int NQ    = cie76_pkg::SQRT_STAGES;
   localparam int RAD_BITS  = 2 * NQ;
   localparam int REM_BITS  = NQ + 2;

   logic [DEPTH-1:0] valid_ff;
   logic             advance;
   logic [cie76_pkg::DIST_BITS-1:0] thresh_ff;

   // whole pipe moves when the output slot is free or being drained
   assign advance   = !valid_ff[DEPTH-1] || rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = valid_ff[DEPTH-1];
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         thresh_ff <= cie76_pkg::THRESH_RESET;
      end else begin
         if (advance) begin
            valid_ff <= {valid_ff[DEPTH-2:0], req_valid};
         end
         if (csr_valid) begin
            thresh_ff <= csr_data;
         end
      end
   end

   // both colors to Lab in parallel
   cie76_pkg::lab_type lab_first, lab_second;

   cie76_lab_convert u_lab_first (
      .clock   (clock),
      .advance (advance),
      .red     (req_payload.first_red),
      .green   (req_payload.first_green),
      .blue    (req_payload.first_blue),
      .lab     (lab_first)
   );

   cie76_lab_convert u_lab_second (
      .clock   (clock),
      .advance (advance),
      .red     (req_payload.second_red),
      .green   (req_payload.second_green),
      .blue    (req_payload.second_blue),
      .lab     (lab_second)
   );

   // squared differences, then their sum
   logic [31:0] sq_ff [3], sq_in [3];
   logic [33:0] sum_ff, sum_in;

   // square root of sum/16, restoring, one root bit per stage
   logic [RAD_BITS-1:0] rad_ff [NQ], rad_in [NQ];
   logic [REM_BITS-1:0] rem_ff [NQ], rem_in [NQ];
   logic [NQ-1:0]       root_ff [NQ], root_in [NQ];

   cie76_pkg::rsp_payload_type rsp_ff, rsp_in;

   always_comb begin
      logic signed [16:0] d [3];
      logic [REM_BITS-1:0] rem_o;
      logic [REM_BITS-1:0] rem_n;
      logic [REM_BITS-1:0] trial;
      logic [RAD_BITS-1:0] rad_o;
      logic [NQ-1:0]       root_o;
      logic [NQ:0]         half;
      d[0] = 17'(lab_first.l) - 17'(lab_second.l);
      d[1] = 17'(lab_first.a) - 17'(lab_second.a);
      d[2] = 17'(lab_first.b) - 17'(lab_second.b);
      for (int i = 0; i < 3; i++) begin
         sq_in[i] = 32'(d[i] * d[i]);
      end
      sum_in = 34'(sq_ff[0]) + 34'(sq_ff[1]) + 34'(sq_ff[2]);

      for (int k = 0; k < NQ; k++) begin
         if (k == 0) begin
            rad_o  = RAD_BITS'(sum_ff >> 4);
            rem_o  = '0;
            root_o = '0;
         end else begin
            rad_o  = rad_ff[(k > 0) ? k - 1 : 0];
            rem_o  = rem_ff[(k > 0) ? k - 1 : 0];
            root_o = root_ff[(k > 0) ? k - 1 : 0];
         end
         rem_n = {rem_o[REM_BITS-3:0], rad_o[RAD_BITS-1 -: 2]};
         trial = {root_o, 2'b01};
         rad_in[k] = rad_o << 2;
         if (rem_n >= trial) begin
            rem_in[k]  = rem_n - trial;
            root_in[k] = {root_o[NQ-2:0], 1'b1};
         end else begin
            rem_in[k]  = rem_n;
            root_in[k] = {root_o[NQ-2:0], 1'b0};
         end
      end

      // round half up and saturate
      half = (NQ+1)'(root_ff[NQ-1]) + (NQ+1)'(1);
      half = half >> 1;
      if (half > (NQ+1)'(cie76_pkg::DIST_MAX)) begin
         rsp_in.distance = cie76_pkg::DIST_MAX;
      end else begin
         rsp_in.distance = cie76_pkg::DIST_BITS'(half);
      end
      rsp_in.is_close = rsp_in.distance < thresh_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= sq_in[i];
         end
         sum_ff <= sum_in;
         for (int k = 0; k < NQ; k++) begin
            rad_ff[k]  <= rad_in[k];
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
         end
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

// ===== hw/rtl/cie76_lab_convert.sv =====
module cie76_lab_convert (
   input  logic                clock,
   input  logic                advance,
   input  cie76_pkg::code_type red,
   input  cie76_pkg::code_type green,
   input  cie76_pkg::code_type blue,
   output cie76_pkg::lab_type  lab
);

   localparam int SUM_BITS  = 30;
   localparam int QX_BITS   = 26;
   localparam int NUM_BITS  = 42;
   localparam int T_BITS    = 25;
   localparam int LQ_BITS   = 26;
   localparam int LNUM_BITS = 46;
   localparam int CX_BITS   = 61;
   localparam int CY2_BITS  = 42;
   localparam int CB_BITS   = 44;
   localparam int NS        = cie76_pkg::CBRT_STAGES;
   localparam int FB        = cie76_pkg::F_BITS;

   function automatic logic signed [15:0] round_sat(input logic signed [31:0] v);
      logic signed [31:0] r;
      r = (v + 32'sd4096) >>> 13;
      if (r > 32'sd32767) begin
         return 16'sh7fff;
      end else if (r < -32'sd32768) begin
         return 16'sh8000;
      end
      return r[15:0];
   endfunction

   cie76_pkg::code_type codes [3];
   assign codes[0] = red;
   assign codes[1] = green;
   assign codes[2] = blue;

   // linearize -> XYZ sums -> ratio to white
   logic [cie76_pkg::LIN_BITS-1:0] lin_ff [3];
   logic [SUM_BITS-1:0]  sum_ff [3],  sum_in [3];
   logic [QX_BITS-1:0]   est3_ff [3], est3_in [3], est4_ff [3];
   logic [NUM_BITS-1:0]  num3_ff [3], num3_in [3], num4_ff [3];
   logic [NUM_BITS-1:0]  prod4_ff [3], prod4_in [3];
   logic [T_BITS-1:0]    t5_ff [3], t5_in [3], t6_ff [3], t7_ff [3], t8_ff [3];
   // linear segment of f
   logic [LQ_BITS-1:0]   lest6_ff [3], lest6_in [3], lest7_ff [3];
   logic [LNUM_BITS-1:0] lnum6_ff [3], lnum6_in [3], lnum7_ff [3];
   logic [LNUM_BITS-1:0] lprod7_ff [3], lprod7_in [3];
   logic [FB-1:0]        flin8_ff [3], flin8_in [3];
   logic                 knee8_ff [3], knee8_in [3];
   // cube root, one result bit per stage
   logic [CX_BITS-1:0]   cx_ff [3][NS],  cx_in [3][NS];
   logic [FB-1:0]        cy_ff [3][NS],  cy_in [3][NS];
   logic [CY2_BITS-1:0]  cy2_ff [3][NS], cy2_in [3][NS];
   logic [FB-1:0]        cfl_ff [3][NS], cfl_in [3][NS];
   logic                 ckn_ff [3][NS], ckn_in [3][NS];
   cie76_pkg::lab_type   lab_ff, lab_in;

   always_comb begin
      logic [NUM_BITS-1:0]  rem;
      logic [LNUM_BITS-1:0] lrem;
      logic [CX_BITS-1:0]   xo;
      logic [CX_BITS-1:0]   xs;
      logic [FB-1:0]        yo;
      logic [FB-1:0]        yd;
      logic [CY2_BITS-1:0]  y2o;
      logic [CY2_BITS-1:0]  y2d;
      logic [CB_BITS-1:0]   bt;
      logic [FB-1:0]        fsel [3];
      logic signed [31:0]   fw [3];
      for (int i = 0; i < 3; i++) begin
         sum_in[i] = '0;
         for (int j = 0; j < 3; j++) begin
            sum_in[i] = sum_in[i] + SUM_BITS'(cie76_pkg::XYZ_COEF[i][j] * lin_ff[j]);
         end
         est3_in[i] = QX_BITS'((64'(sum_ff[i]) * cie76_pkg::DIV_RECIP[i] +
                               cie76_pkg::DIV_BIAS[i]) >> cie76_pkg::DIV_SHIFT);
         num3_in[i] = NUM_BITS'(64'(sum_ff[i]) * cie76_pkg::DIV_MUL[i] +
                                cie76_pkg::DIV_ADD[i]);
         prod4_in[i] = NUM_BITS'(64'(est3_ff[i]) * cie76_pkg::DIV_DEN[i]);
         rem = num4_ff[i] - prod4_ff[i];
         t5_in[i] = T_BITS'(64'(est4_ff[i]) +
                            64'(64'(rem) >= cie76_pkg::DIV_DEN[i]));

         lest6_in[i] = LQ_BITS'((64'(t5_ff[i]) * cie76_pkg::LIN_RECIP +
                                cie76_pkg::LIN_BIAS) >> cie76_pkg::DIV_SHIFT);
         lnum6_in[i] = LNUM_BITS'(64'(t5_ff[i]) * cie76_pkg::LIN_MUL + cie76_pkg::LIN_ADD);
         lprod7_in[i] = LNUM_BITS'(64'(lest6_ff[i]) * cie76_pkg::LIN_DEN);
         lrem = lnum7_ff[i] - lprod7_ff[i];
         flin8_in[i] = FB'(64'(lest7_ff[i]) + 64'(64'(lrem) >= cie76_pkg::LIN_DEN));
         knee8_in[i] = 64'(t7_ff[i]) > cie76_pkg::LAB_KNEE;

         for (int j = 0; j < NS; j++) begin
            if (j == 0) begin
               xo  = {t8_ff[i], {(CX_BITS - T_BITS){1'b0}}};
               yo  = '0;
               y2o = '0;
               cfl_in[i][j] = flin8_ff[i];
               ckn_in[i][j] = knee8_ff[i];
            end else begin
               xo  = cx_ff[i][(j > 0) ? j - 1 : 0];
               yo  = cy_ff[i][(j > 0) ? j - 1 : 0];
               y2o = cy2_ff[i][(j > 0) ? j - 1 : 0];
               cfl_in[i][j] = cfl_ff[i][(j > 0) ? j - 1 : 0];
               ckn_in[i][j] = ckn_ff[i][(j > 0) ? j - 1 : 0];
            end
            yd  = yo << 1;
            y2d = y2o << 2;
            bt  = CB_BITS'(64'd3 * (64'(y2d) + 64'(yd)) + 64'd1);
            xs  = xo >> (3 * (NS - 1 - j));
            if (64'(xs) >= 64'(bt)) begin
               cx_in[i][j]  = xo - CX_BITS'(64'(bt) << (3 * (NS - 1 - j)));
               cy_in[i][j]  = yd + FB'(1);
               cy2_in[i][j] = y2d + CY2_BITS'({yd, 1'b1});
            end else begin
               cx_in[i][j]  = xo;
               cy_in[i][j]  = yd;
               cy2_in[i][j] = y2d;
            end
         end

         fsel[i] = ckn_ff[i][NS-1] ? cy_ff[i][NS-1] : cfl_ff[i][NS-1];
         fw[i]   = signed'(32'(fsel[i]));
      end
      lab_in.l = round_sat(fw[1] * 32'sd116 - cie76_pkg::LAB_L_OFFSET);
      lab_in.a = round_sat((fw[0] - fw[1]) * 32'sd500);
      lab_in.b = round_sat((fw[1] - fw[2]) * 32'sd200);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            lin_ff[i]    <= cie76_pkg::LIN_ROM[codes[i]];
            sum_ff[i]    <= sum_in[i];
            est3_ff[i]   <= est3_in[i];
            num3_ff[i]   <= num3_in[i];
            est4_ff[i]   <= est3_ff[i];
            num4_ff[i]   <= num3_ff[i];
            prod4_ff[i]  <= prod4_in[i];
            t5_ff[i]     <= t5_in[i];
            t6_ff[i]     <= t5_ff[i];
            lest6_ff[i]  <= lest6_in[i];
            lnum6_ff[i]  <= lnum6_in[i];
            t7_ff[i]     <= t6_ff[i];
            lest7_ff[i]  <= lest6_ff[i];
            lnum7_ff[i]  <= lnum6_ff[i];
            lprod7_ff[i] <= lprod7_in[i];
            t8_ff[i]     <= t7_ff[i];
            flin8_ff[i]  <= flin8_in[i];
            knee8_ff[i]  <= knee8_in[i];
            for (int j = 0; j < NS; j++) begin
               cx_ff[i][j]  <= cx_in[i][j];
               cy_ff[i][j]  <= cy_in[i][j];
               cy2_ff[i][j] <= cy2_in[i][j];
               cfl_ff[i][j] <= cfl_in[i][j];
               ckn_ff[i][j] <= ckn_in[i][j];
            end
         end
         lab_ff <= lab_in;
      end
   end

   assign lab = lab_ff;

endmodule

// ===== verif/cie76_delta_e_checker.sv =====
module cie76_delta_e_checker
   import cie76_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_payload_type       req_payload,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_payload_type       rsp_payload,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [DIST_BITS-1:0]  csr_data,
   output int                    fail_count,
   output int                    pending_count,
   output int                    result_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [LIN_BITS-1:0] lin_table_type [LIN_ENTRIES];

   lin_table_type      srgb_linear;
   logic [DIST_BITS-1:0] threshold;
   rsp_payload_type    expected_results [$];

   // sRGB decode table, built with wide integers
   function automatic lin_table_type make_srgb_linear();
      lin_table_type t;
      logic [383:0] den_pow;
      logic [383:0] num_pow;
      logic [383:0] probe;
      longint unsigned m;
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned mid;
      m = (64'd1 << CHANNEL_BITS) - 1;
      den_pow = 384'd1;
      for (int k = 0; k < 12; k++) den_pow = den_pow * 384'(1055 * m);
      for (longint unsigned c = 0; c <= m; c++) begin
         if (100000 * c <= 4045 * m) begin
            t[c] = LIN_BITS'((13107200 * c + 1292 * m) / (2584 * m));
         end else begin
            num_pow = 384'd1;
            for (int k = 0; k < 12; k++) num_pow = num_pow * 384'(1000 * c + 55 * m);
            num_pow = num_pow << 85;
            lo = 0;
            hi = 65536;
            while (lo < hi) begin
               mid = (lo + hi + 1) >> 1;
               probe = den_pow;
               for (int k = 0; k < 5; k++) probe = probe * 384'(2 * mid - 1);
               if (probe <= num_pow) lo = mid;
               else hi = mid - 1;
            end
            t[c] = LIN_BITS'(lo);
         end
      end
      return t;
   endfunction

   function automatic longint unsigned cube_root_floor(longint unsigned v);
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned mid;
      lo = 0;
      hi = (64'd1 << 21) - 1;
      while (lo < hi) begin
         mid = (lo + hi + 1) >> 1;
         if (mid * mid * mid <= v) lo = mid;
         else hi = mid - 1;
      end
      return lo;
   endfunction

   function automatic longint unsigned square_root_floor(longint unsigned v);
      longint unsigned r;
      longint unsigned bitv;
      r = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= r + bitv) begin
            v -= r + bitv;
            r = (r >> 1) + bitv;
         end else begin
            r >>= 1;
         end
         bitv >>= 2;
      end
      return r;
   endfunction

   function automatic longint lab_curve(longint unsigned t24);
      if (t24 * 1000000 > (64'd8856 << 24)) return longint'(cube_root_floor(t24 << 36));
      return longint'((7787 * t24 * 116 + (64'd16 << 20) * 16000 + 928000) / 1856000);
   endfunction

   function automatic longint q13_round_sat(longint v);
      longint r;
      r = ((v + 4096) >>> 13);
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r;
   endfunction

   function automatic void srgb_to_lab(code_type rc, code_type gc, code_type bc,
                                       output longint lab [3]);
      longint unsigned r, g, b, sx, sy, sz, tx, ty, tz;
      longint fx, fy, fz;
      r = srgb_linear[rc];
      g = srgb_linear[gc];
      b = srgb_linear[bc];
      sx = 4124 * r + 3576 * g + 1805 * b;
      sy = 2126 * r + 7152 * g + 722 * b;
      sz = 193 * r + 1192 * g + 9505 * b;
      tx = (5120 * sx + 95047) / 190094;
      ty = (sy * 256 + 5000) / 10000;
      tz = (5120 * sz + 108883) / 217766;
      fx = lab_curve(tx);
      fy = lab_curve(ty);
      fz = lab_curve(tz);
      lab[0] = q13_round_sat(116 * fy - (64'sd16 << 20));
      lab[1] = q13_round_sat(500 * (fx - fy));
      lab[2] = q13_round_sat(200 * (fy - fz));
   endfunction

   function automatic rsp_payload_type delta_e_of(req_payload_type p);
      longint l1 [3];
      longint l2 [3];
      longint unsigned s;
      longint unsigned d;
      rsp_payload_type o;
      srgb_to_lab(p.first_red, p.first_green, p.first_blue, l1);
      srgb_to_lab(p.second_red, p.second_green, p.second_blue, l2);
      s = 0;
      for (int i = 0; i < 3; i++) s += longint'((l1[i] - l2[i]) * (l1[i] - l2[i]));
      d = (square_root_floor(s >> 4) + 1) >> 1;
      if (d > 8191) d = 8191;
      o.distance = DIST_BITS'(d);
      o.is_close = (o.distance < threshold);
      return o;
   endfunction

   initial srgb_linear = make_srgb_linear();

   assign pending_count = expected_results.size();

   always @(posedge clock) begin
      rsp_payload_type want;
      int errs;
      if (reset) begin
         threshold <= THRESH_RESET;
         expected_results.delete();
         fail_count <= 0;
         result_count <= 0;
      end else begin
         // responses trail their requests in the pipe, so pop before push is safe
         if (rsp_valid && rsp_ready) begin
            result_count <= result_count + 1;
            if (expected_results.size() == 0) begin
               $error("response with nothing expected: %p", rsp_payload);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_results.pop_front();
               errs = 0;
               if (want.distance !== rsp_payload.distance) begin
                  $error("distance expected %0d actual %0d", want.distance,
                         rsp_payload.distance);
                  errs = errs + 1;
               end
               if (want.is_close !== rsp_payload.is_close) begin
                  $error("is_close expected %0d actual %0d", want.is_close,
                         rsp_payload.is_close);
                  errs = errs + 1;
               end
               fail_count <= fail_count + errs;
            end
         end
         if (req_valid && req_ready) expected_results.push_back(delta_e_of(req_payload));
         if (csr_valid && csr_ready) threshold <= csr_data;
      end
   end
endmodule

// ===== verif/tb_cie76_color_difference_unit.sv =====
module tb_cie76_color_difference_unit;
   import cie76_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 1750;
   localparam int IDLE_LIMIT   = 20000;   // cycles with no transaction at all
   localparam int DRAIN_CYCLES = PIPE_DEPTH + 20;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   req_payload_type      req_payload;
   logic                 rsp_valid;
   logic                 rsp_ready;
   rsp_payload_type      rsp_payload;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [DIST_BITS-1:0] csr_data;
   int                   fail_count;
   int                   pending_count;
   int                   result_count;
   int                   idle_cycles;
   bit                   calm_phase;   // no idling at the end of the run
   bit                   hold_rsp;     // long receiver stall request
   bit                   stimulus_done;

   cie76_color_difference_unit dut (.*);

   cie76_delta_e_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // watchdog: stalls that go on too long end the run
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("FAIL cie76_color_difference_unit");
            $finish;
         end
      end
   end

   // receiver: random stall bursts, plus one long hold that fills the pipe
   initial begin
      int n;
      rsp_ready = 0;
      @(negedge clock);
      while (!stimulus_done || pending_count != 0) begin
         if (hold_rsp) begin
            rsp_ready <= 0;
            for (int i = 0; i < 150; i++) @(negedge clock);
            hold_rsp = 0;
         end else if (!calm_phase && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 0;
            n = $urandom_range(1, 10);
            repeat (n) @(negedge clock);
         end else begin
            rsp_ready <= 1;
            @(negedge clock);
         end
      end
      rsp_ready <= 1;
   end

   task automatic send_pair(req_payload_type p, bit gaps);
      int n;
      if (gaps && !calm_phase && $urandom_range(0, 4) == 0) begin
         req_valid <= 0;
         n = $urandom_range(1, 10);
         repeat (n) @(negedge clock);
      end
      req_valid   <= 1;
      req_payload <= p;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_colors(code_type r1, code_type g1, code_type b1,
                              code_type r2, code_type g2, code_type b2);
      req_payload_type p;
      p = '{r1, g1, b1, r2, g2, b2};
      send_pair(p, 1);
   endtask

   function automatic req_payload_type random_pair();
      req_payload_type p;
      p = req_payload_type'(48'({$urandom, $urandom}));
      // a third are near-identical colors, so the threshold decision is exercised
      if ($urandom_range(0, 2) == 0) begin
         p.second_red   = code_type'(32'(p.first_red) + $urandom_range(0, 4) - 2);
         p.second_green = code_type'(32'(p.first_green) + $urandom_range(0, 4) - 2);
         p.second_blue  = code_type'(32'(p.first_blue) + $urandom_range(0, 4) - 2);
      end
      return p;
   endfunction

   // quiet the request side and let every outstanding result come back
   task automatic drain();
      req_valid <= 0;
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_threshold(logic [DIST_BITS-1:0] v);
      csr_valid <= 1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   initial begin
      logic [DIST_BITS-1:0] settings [5];
      settings = '{THRESH_RESET, 0, DIST_MAX, 16, 400};
      reset = 1;
      req_valid = 0;
      req_payload = '0;
      csr_valid = 0;
      csr_data = '0;
      calm_phase = 0;
      hold_rsp = 0;
      stimulus_done = 0;
      repeat (6) @(negedge clock);
      reset = 0;

      // directed: extremes, equal colors, primaries, near-threshold steps
      send_colors(0, 0, 0, 0, 0, 0);
      send_colors(255, 255, 255, 255, 255, 255);
      send_colors(0, 0, 0, 255, 255, 255);
      send_colors(255, 255, 255, 0, 0, 0);
      send_colors(255, 0, 0, 0, 255, 0);
      send_colors(0, 0, 255, 255, 255, 0);
      send_colors(255, 0, 255, 0, 255, 0);
      send_colors(10, 10, 10, 11, 10, 10);      // across the sRGB knee
      send_colors(11, 11, 11, 12, 12, 12);      // both above the sRGB knee
      send_colors(2, 2, 2, 3, 3, 3);            // dark: linear branch of f(t)
      send_colors(128, 128, 128, 131, 129, 128);
      send_colors(200, 100, 50, 203, 100, 50);
      send_colors(8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55);
      send_colors(1, 254, 1, 254, 1, 254);
      drain();

      // threshold sweep, reset value first, zero and all ones among them
      foreach (settings[s]) begin
         write_threshold(settings[s]);
         if (s == 1) hold_rsp = 1;   // pipe fills and req_ready drops
         for (int i = 0; i < RANDOM_ITEMS / 5; i++) begin
            if (s == 4 && i > RANDOM_ITEMS / 10) calm_phase = 1;
            send_pair(random_pair(), 1);
         end
         drain();
      end
      stimulus_done = 1;
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("covered %0d color pairs over %0d threshold settings incl. 0 and max",
               result_count, $size(settings));
      if (fail_count == 0) begin
         $display("PASS cie76_color_difference_unit");
      end else begin
         $display("FAIL cie76_color_difference_unit");
      end
      $finish;
   end
endmodule
